// ----- src/lct_pkg.sv -----
package lct_pkg;

    localparam int VAL_W      = 32;
    localparam int EXP_W      = 32;
    localparam int CNT_W      = 32;
    localparam int SAV_W      = 48;
    localparam int TTL_W      = 16;
    localparam int MAXE_W     = 7;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int KEY_IN_W   = 64;
    localparam int COUNT_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE      = 2'd0,
        REG_MAX_ENTRIES = 2'd1,
        REG_TTL         = 2'd2
    } t_reg_idx;

    // operation applied by every cell in the same cycle
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_DROP    = 3'd1,
        OP_PROMOTE = 3'd2,
        OP_EVICT   = 3'd3,
        OP_STORE   = 3'd4,
        OP_CLEAR   = 3'd5
    } t_op;

    typedef struct packed {
        t_op  kind;
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_LOOK_END,
        S_KEY,
        S_KEY_END,
        S_EVICT,
        S_SWEEP,
        S_SWEEP_END,
        S_STORE,
        S_DONE
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ----- src/lct_cell.sv -----
module lct_cell #(
    parameter int KEY_BITS = 64,
    parameter int RANK_W   = 6,
    parameter bit IS_TAIL  = 1'b0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lct_pkg::t_cell_ctl         i_ctl,
    input  logic [RANK_W-1:0]          i_op_rank,
    input  logic                       i_nb_valid,
    input  logic [RANK_W-1:0]          i_nb_rank,
    input  logic [KEY_BITS-1:0]        i_nb_key,
    input  logic [lct_pkg::VAL_W-1:0]  i_nb_val,
    input  logic [lct_pkg::VAL_W-1:0]  i_nb_cost,
    input  logic [lct_pkg::EXP_W-1:0]  i_nb_exp,
    input  logic [KEY_BITS-1:0]        i_ld_key,
    input  logic [lct_pkg::VAL_W-1:0]  i_ld_val,
    input  logic [lct_pkg::VAL_W-1:0]  i_ld_cost,
    input  logic [lct_pkg::EXP_W-1:0]  i_ld_exp,
    output logic                       o_u_valid,
    output logic [RANK_W-1:0]          o_u_rank,
    output logic [KEY_BITS-1:0]        o_u_key,
    output logic [lct_pkg::VAL_W-1:0]  o_u_val,
    output logic [lct_pkg::VAL_W-1:0]  o_u_cost,
    output logic [lct_pkg::EXP_W-1:0]  o_u_exp,
    output logic                       o_q_valid
);
    import lct_pkg::*;

    logic                r_valid, n_valid;
    logic [RANK_W-1:0]   r_rank, n_rank;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [VAL_W-1:0]    r_cost, n_cost;
    logic [EXP_W-1:0]    r_exp, n_exp;

    logic                u_valid;
    logic [RANK_W-1:0]   u_rank;

    // updated entry before the ring shift; the tail holds the entry just shifted in from the head
    always_comb begin
        u_valid = r_valid;
        u_rank  = r_rank;
        unique case (i_ctl.kind)
            OP_NONE: begin
            end
            OP_DROP: begin
                if (IS_TAIL) begin
                    u_valid = 1'b0;
                end else if (r_valid && r_rank > i_op_rank) begin
                    u_rank = r_rank - 1'b1;
                end
            end
            OP_PROMOTE: begin
                if (IS_TAIL) begin
                    u_rank = '0;
                end else if (r_valid && r_rank < i_op_rank) begin
                    u_rank = r_rank + 1'b1;
                end
            end
            OP_EVICT: begin
                if (r_valid && r_rank == i_op_rank) begin
                    u_valid = 1'b0;
                end
            end
            OP_STORE: begin
                if (r_valid) begin
                    u_rank = r_rank + 1'b1;
                end
            end
            OP_CLEAR: begin
                u_valid = 1'b0;
                u_rank  = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (i_ctl.shift) begin
            n_valid = i_nb_valid;
            n_rank  = i_nb_rank;
            n_key   = i_nb_key;
            n_val   = i_nb_val;
            n_cost  = i_nb_cost;
            n_exp   = i_nb_exp;
        end else if (i_ctl.load) begin
            n_valid = 1'b1;
            n_rank  = '0;
            n_key   = i_ld_key;
            n_val   = i_ld_val;
            n_cost  = i_ld_cost;
            n_exp   = i_ld_exp;
        end else begin
            n_valid = u_valid;
            n_rank  = u_rank;
            n_key   = r_key;
            n_val   = r_val;
            n_cost  = r_cost;
            n_exp   = r_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_val  <= n_val;
        r_cost <= n_cost;
        r_exp  <= n_exp;
    end

    assign o_u_valid = u_valid;
    assign o_u_rank  = u_rank;
    assign o_u_key   = r_key;
    assign o_u_val   = r_val;
    assign o_u_cost  = r_cost;
    assign o_u_exp   = r_exp;
    assign o_q_valid = r_valid;

endmodule

// ----- src/lct_ctrl.sv -----
module lct_ctrl #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lct_pkg::CMD_W-1:0]       i_command,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [lct_pkg::VAL_W-1:0]       i_value_handle,
    input  logic [lct_pkg::VAL_W-1:0]       i_cost,
    input  logic                            i_no_store,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic [lct_pkg::VAL_W-1:0]       o_value_out,
    output logic [lct_pkg::COUNT_W-1:0]     o_entry_count,
    output logic [lct_pkg::CNT_W-1:0]       o_hit_total,
    output logic [lct_pkg::CNT_W-1:0]       o_miss_total,
    output logic [lct_pkg::CNT_W-1:0]       o_eviction_total,
    output logic [lct_pkg::SAV_W-1:0]       o_savings_total,
    input  logic                            i_head_valid,
    input  logic [$clog2(ENTRIES)-1:0]      i_head_rank,
    input  logic [KEY_BITS-1:0]             i_head_key,
    input  logic [lct_pkg::VAL_W-1:0]       i_head_val,
    input  logic [lct_pkg::VAL_W-1:0]       i_head_cost,
    input  logic [lct_pkg::EXP_W-1:0]       i_head_exp,
    input  logic                            i_head_q_valid,
    output lct_pkg::t_cell_ctl              o_ctl,
    output logic [$clog2(ENTRIES)-1:0]      o_op_rank,
    output logic [KEY_BITS-1:0]             o_ld_key,
    output logic [lct_pkg::VAL_W-1:0]       o_ld_val,
    output logic [lct_pkg::VAL_W-1:0]       o_ld_cost,
    output logic [lct_pkg::EXP_W-1:0]       o_ld_exp
);
    import lct_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int OCC_W  = $clog2(ENTRIES + 1);

    t_state              r_state, n_state;
    logic                r_enable, n_enable;
    logic [MAXE_W-1:0]   r_max, n_max;
    logic [TTL_W-1:0]    r_ttl, n_ttl;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [VAL_W-1:0]    r_cost, n_cost;
    t_op                 r_pend, n_pend;
    logic [RANK_W-1:0]   r_pend_rank, n_pend_rank;
    logic [RANK_W-1:0]   r_cnt, n_cnt;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [EXP_W-1:0]    r_time, n_time;
    logic [CNT_W-1:0]    r_hits, n_hits;
    logic [CNT_W-1:0]    r_misses, n_misses;
    logic [CNT_W-1:0]    r_evicts, n_evicts;
    logic [SAV_W-1:0]    r_sav, n_sav;
    logic                r_hit, n_hit;
    logic [VAL_W-1:0]    r_value, n_value;
    logic                r_out_valid, n_out_valid;

    t_cmd                in_cmd;
    logic                accept;
    logic                last;
    logic [OCC_W-1:0]    cap;
    logic                evict_go;
    logic                sweep_go;
    logic                head_match;
    logic                head_expired;
    logic [EXP_W:0]      exp_sum;
    logic [SAV_W:0]      sav_sum;

    assign in_cmd       = t_cmd'(i_command);
    assign o_in_ready   = (r_state == S_IDLE) && !r_out_valid;
    assign accept       = i_in_valid && o_in_ready;
    assign last         = (r_cnt == RANK_W'(ENTRIES - 1));
    assign head_match   = i_head_valid && (i_head_key == r_key);
    assign head_expired = r_time > i_head_exp;
    assign exp_sum      = {1'b0, r_time} + (EXP_W + 1)'(r_ttl);
    assign sav_sum      = {1'b0, r_sav} + (SAV_W + 1)'(i_head_cost);

    // capacity in use, clamped to one and to the built entry count
    always_comb begin
        if (r_max == '0) begin
            cap = OCC_W'(1);
        end else if (32'(r_max) > 32'(ENTRIES)) begin
            cap = OCC_W'(ENTRIES);
        end else begin
            cap = OCC_W'(r_max);
        end
    end

    assign evict_go = (r_occ >= cap) && (r_occ != '0);
    assign sweep_go = r_occ > (cap >> 1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_LOOKUP: n_state = r_enable ? S_LOOK : S_DONE;
                        CMD_INSERT: n_state = (r_enable && !i_no_store) ? S_KEY : S_DONE;
                        CMD_TICK:   n_state = S_DONE;
                        CMD_CLEAR:  n_state = S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_LOOK:      if (last) n_state = S_LOOK_END;
            S_LOOK_END:  n_state = S_DONE;
            S_KEY:       if (last) n_state = S_KEY_END;
            S_KEY_END:   n_state = S_EVICT;
            S_EVICT: begin
                if (!evict_go) begin
                    n_state = sweep_go ? S_SWEEP : S_STORE;
                end
            end
            S_SWEEP:     if (last) n_state = S_SWEEP_END;
            S_SWEEP_END: n_state = S_STORE;
            S_STORE:     if (!i_head_q_valid) n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // cell row control
    always_comb begin
        o_ctl     = '{kind: OP_NONE, shift: 1'b0, load: 1'b0};
        o_op_rank = r_pend_rank;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_cmd == CMD_CLEAR) begin
                    o_ctl.kind = OP_CLEAR;
                end
            end
            S_LOOK, S_KEY, S_SWEEP: begin
                o_ctl.kind  = r_pend;
                o_ctl.shift = 1'b1;
            end
            S_LOOK_END, S_KEY_END, S_SWEEP_END: begin
                o_ctl.kind = r_pend;
            end
            S_EVICT: begin
                if (evict_go) begin
                    o_ctl.kind = OP_EVICT;
                    o_op_rank  = RANK_W'(r_occ - 1'b1);
                end
            end
            S_STORE: begin
                if (i_head_q_valid) begin
                    o_ctl.shift = 1'b1;
                end else begin
                    o_ctl.kind = OP_STORE;
                    o_ctl.load = 1'b1;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_ld_key  = r_key;
    assign o_ld_val  = r_val;
    assign o_ld_cost = r_cost;
    assign o_ld_exp  = exp_sum[EXP_W] ? '1 : exp_sum[EXP_W-1:0];

    // datapath
    always_comb begin
        n_enable    = r_enable;
        n_max       = r_max;
        n_ttl       = r_ttl;
        n_key       = r_key;
        n_val       = r_val;
        n_cost      = r_cost;
        n_pend      = r_pend;
        n_pend_rank = r_pend_rank;
        n_cnt       = r_cnt;
        n_occ       = r_occ;
        n_time      = r_time;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_evicts    = r_evicts;
        n_sav       = r_sav;
        n_hit       = r_hit;
        n_value     = r_value;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ENABLE:      n_enable = i_cfg_wdata[0];
                REG_MAX_ENTRIES: n_max    = i_cfg_wdata[MAXE_W-1:0];
                REG_TTL:         n_ttl    = i_cfg_wdata[TTL_W-1:0];
                default: begin
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key   = i_key;
                    n_val   = i_value_handle;
                    n_cost  = i_cost;
                    n_hit   = 1'b0;
                    n_value = '0;
                    n_pend  = OP_NONE;
                    n_cnt   = '0;
                    unique case (in_cmd)
                        CMD_LOOKUP: if (!r_enable) n_misses = sat_inc(r_misses);
                        CMD_INSERT: begin
                        end
                        CMD_TICK:   n_time = sat_inc(r_time);
                        CMD_CLEAR:  n_occ = '0;
                        default: begin
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_cnt  = r_cnt + 1'b1;
                n_pend = OP_NONE;
                if (head_match) begin
                    n_pend_rank = i_head_rank;
                    if (head_expired) begin
                        n_pend = OP_DROP;
                        n_occ  = r_occ - 1'b1;
                    end else begin
                        n_pend  = OP_PROMOTE;
                        n_hit   = 1'b1;
                        n_value = i_head_val;
                        n_hits  = sat_inc(r_hits);
                        n_sav   = sav_sum[SAV_W] ? '1 : sav_sum[SAV_W-1:0];
                    end
                end
            end
            S_LOOK_END: begin
                n_pend = OP_NONE;
                if (!r_hit) n_misses = sat_inc(r_misses);
            end
            S_KEY: begin
                n_cnt  = r_cnt + 1'b1;
                n_pend = OP_NONE;
                if (head_match) begin
                    n_pend      = OP_DROP;
                    n_pend_rank = i_head_rank;
                    n_occ       = r_occ - 1'b1;
                end
            end
            S_KEY_END: begin
                n_pend = OP_NONE;
            end
            S_EVICT: begin
                n_cnt = '0;
                if (evict_go) begin
                    n_occ    = r_occ - 1'b1;
                    n_evicts = sat_inc(r_evicts);
                end
            end
            S_SWEEP: begin
                n_cnt  = r_cnt + 1'b1;
                n_pend = OP_NONE;
                if (i_head_valid && head_expired) begin
                    n_pend      = OP_DROP;
                    n_pend_rank = i_head_rank;
                    n_occ       = r_occ - 1'b1;
                    n_evicts    = sat_inc(r_evicts);
                end
            end
            S_SWEEP_END: begin
                n_pend = OP_NONE;
            end
            S_STORE: begin
                if (!i_head_q_valid) n_occ = r_occ + 1'b1;
            end
            S_DONE: begin
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_max       <= MAXE_W'(64);
            r_ttl       <= TTL_W'(3600);
            r_pend      <= OP_NONE;
            r_cnt       <= '0;
            r_occ       <= '0;
            r_time      <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_sav       <= '0;
            r_hit       <= 1'b0;
            r_value     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enable    <= n_enable;
            r_max       <= n_max;
            r_ttl       <= n_ttl;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_occ       <= n_occ;
            r_time      <= n_time;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_evicts    <= n_evicts;
            r_sav       <= n_sav;
            r_hit       <= n_hit;
            r_value     <= n_value;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_val       <= n_val;
        r_cost      <= n_cost;
        r_pend_rank <= n_pend_rank;
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_hit;
    assign o_value_out      = r_value;
    assign o_entry_count    = COUNT_W'(r_occ);
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;
    assign o_savings_total  = r_sav;

endmodule

// ----- src/lru_cache_with_ttl_expiry.sv -----
// LRU cache with per-entry expiry. Entries live in a ring of ENTRIES cells that
// rotates one place per cycle while a command scans it, past a single compare
// point at the head; rank updates are applied by every cell at once. A lookup
// makes one full turn of the ring; a stored insert makes one full turn to drop
// an old copy of its key, evicts LRU entries, makes one more full turn for the
// expiry sweep when more than half full, and rotates a free cell to the head.
// One item is in flight at a time; the next is taken once the result beat has left.
module lru_cache_with_ttl_expiry #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lct_pkg::CMD_W-1:0]       i_command,
    input  logic [lct_pkg::KEY_IN_W-1:0]    i_key,
    input  logic [lct_pkg::VAL_W-1:0]       i_value_handle,
    input  logic [lct_pkg::VAL_W-1:0]       i_cost,
    input  logic                            i_no_store,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic [lct_pkg::VAL_W-1:0]       o_value_out,
    output logic [lct_pkg::COUNT_W-1:0]     o_entry_count,
    output logic [lct_pkg::CNT_W-1:0]       o_hit_total,
    output logic [lct_pkg::CNT_W-1:0]       o_miss_total,
    output logic [lct_pkg::CNT_W-1:0]       o_eviction_total,
    output logic [lct_pkg::SAV_W-1:0]       o_savings_total
);
    import lct_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);

    t_cell_ctl           ctl;
    logic [RANK_W-1:0]   op_rank;
    logic [KEY_BITS-1:0] ld_key;
    logic [VAL_W-1:0]    ld_val;
    logic [VAL_W-1:0]    ld_cost;
    logic [EXP_W-1:0]    ld_exp;

    t_cell_ctl           cell_ctl [ENTRIES];
    logic                u_valid  [ENTRIES];
    logic [RANK_W-1:0]   u_rank   [ENTRIES];
    logic [KEY_BITS-1:0] u_key    [ENTRIES];
    logic [VAL_W-1:0]    u_val    [ENTRIES];
    logic [VAL_W-1:0]    u_cost   [ENTRIES];
    logic [EXP_W-1:0]    u_exp    [ENTRIES];
    logic                q_valid  [ENTRIES];

    lct_ctrl #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_key            (i_key[KEY_BITS-1:0]),
        .i_value_handle   (i_value_handle),
        .i_cost           (i_cost),
        .i_no_store       (i_no_store),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hit            (o_hit),
        .o_value_out      (o_value_out),
        .o_entry_count    (o_entry_count),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total),
        .o_savings_total  (o_savings_total),
        .i_head_valid     (u_valid[0]),
        .i_head_rank      (u_rank[0]),
        .i_head_key       (u_key[0]),
        .i_head_val       (u_val[0]),
        .i_head_cost      (u_cost[0]),
        .i_head_exp       (u_exp[0]),
        .i_head_q_valid   (q_valid[0]),
        .o_ctl            (ctl),
        .o_op_rank        (op_rank),
        .o_ld_key         (ld_key),
        .o_ld_val         (ld_val),
        .o_ld_cost        (ld_cost),
        .o_ld_exp         (ld_exp)
    );

    // each cell takes its neighbour's updated entry; the last cell takes the head's, closing the ring
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        localparam int NB = (g + 1) % ENTRIES;

        assign cell_ctl[g] = '{kind: ctl.kind, shift: ctl.shift, load: ctl.load && (g == 0)};

        lct_cell #(
            .KEY_BITS (KEY_BITS),
            .RANK_W   (RANK_W),
            .IS_TAIL  (g == ENTRIES - 1)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl[g]),
            .i_op_rank  (op_rank),
            .i_nb_valid (u_valid[NB]),
            .i_nb_rank  (u_rank[NB]),
            .i_nb_key   (u_key[NB]),
            .i_nb_val   (u_val[NB]),
            .i_nb_cost  (u_cost[NB]),
            .i_nb_exp   (u_exp[NB]),
            .i_ld_key   (ld_key),
            .i_ld_val   (ld_val),
            .i_ld_cost  (ld_cost),
            .i_ld_exp   (ld_exp),
            .o_u_valid  (u_valid[g]),
            .o_u_rank   (u_rank[g]),
            .o_u_key    (u_key[g]),
            .o_u_val    (u_val[g]),
            .o_u_cost   (u_cost[g]),
            .o_u_exp    (u_exp[g]),
            .o_q_valid  (q_valid[g])
        );
    end

endmodule

// ----- tb/sv/lru_cache_with_ttl_expiry_test.sv -----
`timescale 1ns / 1ps

module lru_cache_with_ttl_expiry_test;
    import lct_pkg::*;

    localparam int SLOTS      = 64;
    localparam int STALL_MAX  = 20000;
    localparam int POOL_SIZE  = 24;

    typedef struct {
        t_cmd              cmd;
        logic [63:0]       key;
        logic [31:0]       value;
        logic [31:0]       cost;
        logic              no_store;
    } t_request;

    typedef struct {
        logic              hit;
        logic [31:0]       value;
        logic [6:0]        count;
        logic [31:0]       hits;
        logic [31:0]       misses;
        logic [31:0]       evictions;
        logic [47:0]       savings;
    } t_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [CMD_W-1:0]       i_command = CMD_LOOKUP;
    logic [63:0]            i_key = '0;
    logic [31:0]            i_value_handle = '0;
    logic [31:0]            i_cost = '0;
    logic                   i_no_store = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_hit;
    logic [31:0]            o_value_out;
    logic [6:0]             o_entry_count;
    logic [31:0]            o_hit_total;
    logic [31:0]            o_miss_total;
    logic [31:0]            o_eviction_total;
    logic [47:0]            o_savings_total;

    lru_cache_with_ttl_expiry u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // cache shadow
    logic        enabled_q;
    int unsigned cap_reg_q;
    int unsigned ttl_q;
    logic [63:0] slot_key [SLOTS];
    logic [31:0] slot_val [SLOTS];
    logic [31:0] slot_cost [SLOTS];
    logic [31:0] slot_exp [SLOTS];
    bit          slot_live [SLOTS];
    int unsigned slot_rank [SLOTS];
    int unsigned held;
    logic [31:0] now_q;
    logic [31:0] hits_q, misses_q, evicts_q;
    logic [47:0] savings_q;

    t_request    pending_reqs[$];
    t_outcome    awaited[$];
    t_request    cur_req;
    logic [63:0] key_pool [POOL_SIZE];
    int          errors = 0;
    int          cycle_no = 0;
    int          stall_cnt = 0;

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function automatic void vacate(int s);
        int unsigned r;
        r = slot_rank[s];
        slot_live[s] = 0;
        slot_rank[s] = 0;
        for (int j = 0; j < SLOTS; j++)
            if (slot_live[j] && slot_rank[j] > r) slot_rank[j]--;
        if (held > 0) held--;
    endfunction

    function automatic int locate(logic [63:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void retire_oldest();
        int v;
        v = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && (v < 0 || slot_rank[i] > slot_rank[v])) v = i;
        if (v >= 0) begin
            vacate(v);
            evicts_q = bump(evicts_q);
        end
    endfunction

    function automatic void place(t_request rq);
        int s;
        logic [32:0] e;
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (!slot_live[i] && s < 0) s = i;
        if (s < 0) return;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i]) slot_rank[i]++;
        e = {1'b0, now_q} + ttl_q;
        slot_key[s] = rq.key;
        slot_val[s] = rq.value;
        slot_cost[s] = rq.cost;
        slot_exp[s] = e[32] ? 32'hFFFF_FFFF : e[31:0];
        slot_live[s] = 1;
        slot_rank[s] = 0;
        held++;
    endfunction

    function automatic t_outcome cache_step(t_request rq);
        t_outcome o;
        int i;
        int unsigned cap, r;
        logic [48:0] sum;
        o.hit = 0;
        o.value = 0;
        case (rq.cmd)
            CMD_LOOKUP: begin
                i = enabled_q ? locate(rq.key) : -1;
                if (i >= 0 && now_q > slot_exp[i]) begin
                    vacate(i);
                    i = -1;
                end
                if (i < 0) begin
                    misses_q = bump(misses_q);
                end else begin
                    r = slot_rank[i];
                    for (int j = 0; j < SLOTS; j++)
                        if (slot_live[j] && slot_rank[j] < r) slot_rank[j]++;
                    slot_rank[i] = 0;
                    hits_q = bump(hits_q);
                    sum = {1'b0, savings_q} + slot_cost[i];
                    savings_q = sum[48] ? '1 : sum[47:0];
                    o.hit = 1;
                    o.value = slot_val[i];
                end
            end
            CMD_INSERT: begin
                if (enabled_q && !rq.no_store) begin
                    cap = (cap_reg_q == 0) ? 1 : (cap_reg_q > SLOTS ? SLOTS : cap_reg_q);
                    i = locate(rq.key);
                    if (i >= 0) vacate(i);
                    while (held >= cap && held > 0) retire_oldest();
                    if (held > cap / 2) begin
                        for (int j = 0; j < SLOTS; j++)
                            if (slot_live[j] && now_q > slot_exp[j]) begin
                                vacate(j);
                                evicts_q = bump(evicts_q);
                            end
                    end
                    place(rq);
                end
            end
            CMD_TICK: now_q = bump(now_q);
            default: begin
                for (int j = 0; j < SLOTS; j++) begin
                    slot_live[j] = 0;
                    slot_rank[j] = 0;
                end
                held = 0;
            end
        endcase
        o.count = held[6:0];
        o.hits = hits_q;
        o.misses = misses_q;
        o.evictions = evicts_q;
        o.savings = savings_q;
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_no, field, got, want);
    endtask

    function automatic bit quiet_side();
        // long calm window with no idling
        if (cycle_no > 4000 && cycle_no < 60000) return 0;
        return $urandom_range(99) < 19;
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit fire;
        cycle_no <= cycle_no + 1;
        if (i_rst_n) begin
            fire = i_in_valid && o_in_ready;
            if (fire) awaited.push_back(cache_step(cur_req));
            if (!i_in_valid || fire) begin
                if (pending_reqs.size() > 0 && !quiet_side()) begin
                    cur_req = pending_reqs.pop_front();
                    i_command <= cur_req.cmd;
                    i_key <= cur_req.key;
                    i_value_handle <= cur_req.value;
                    i_cost <= cur_req.cost;
                    i_no_store <= cur_req.no_store;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !quiet_side();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited.size() == 0) begin
                report_mismatch("unexpected beat", 64'd1, 64'd0);
            end else begin
                w = awaited.pop_front();
                if (o_hit !== w.hit) report_mismatch("hit", 64'(o_hit), 64'(w.hit));
                if (o_value_out !== w.value)
                    report_mismatch("value_out", 64'(o_value_out), 64'(w.value));
                if (o_entry_count !== w.count)
                    report_mismatch("entry_count", 64'(o_entry_count), 64'(w.count));
                if (o_hit_total !== w.hits)
                    report_mismatch("hit_total", 64'(o_hit_total), 64'(w.hits));
                if (o_miss_total !== w.misses)
                    report_mismatch("miss_total", 64'(o_miss_total), 64'(w.misses));
                if (o_eviction_total !== w.evictions)
                    report_mismatch("eviction_total", 64'(o_eviction_total),
                                    64'(w.evictions));
                if (o_savings_total !== w.savings)
                    report_mismatch("savings_total", 64'(o_savings_total), 64'(w.savings));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (pending_reqs.size() == 0 && awaited.size() == 0 && !i_in_valid)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_MAX) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic push_req(t_cmd c, logic [63:0] k, logic [31:0] v, logic [31:0] cs, logic ns);
        t_request rq;
        rq.cmd = c;
        rq.key = k;
        rq.value = v;
        rq.cost = cs;
        rq.no_store = ns;
        pending_reqs.push_back(rq);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || awaited.size() > 0 || i_in_valid) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_ENABLE:      enabled_q = data[0];
            REG_MAX_ENTRIES: cap_reg_q = 32'(data[6:0]);
            default:         ttl_q = 32'(data);
        endcase
    endtask

    task automatic configure(logic en, logic [15:0] cap, logic [15:0] ttl);
        drain();
        write_reg(REG_ENABLE, {15'd0, en});
        write_reg(REG_MAX_ENTRIES, cap);
        write_reg(REG_TTL, ttl);
    endtask

    task automatic random_batch(int n);
        int w;
        logic [63:0] k;
        for (int c = 0; c < n; c++) begin
            w = $urandom_range(99);
            k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(POOL_SIZE-1)]
                                        : {$urandom, $urandom};
            push_req(w < 40 ? CMD_LOOKUP : w < 75 ? CMD_INSERT : w < 97 ? CMD_TICK : CMD_CLEAR,
                     k, $urandom, $urandom, $urandom_range(9) == 0);
        end
    endtask

    initial begin
        enabled_q = 1;
        cap_reg_q = 64;
        ttl_q = 3600;
        held = 0;
        now_q = 0;
        hits_q = 0;
        misses_q = 0;
        evicts_q = 0;
        savings_q = 0;
        for (int j = 0; j < SLOTS; j++) begin
            slot_live[j] = 0;
            slot_rank[j] = 0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int j = 2; j < POOL_SIZE; j++) key_pool[j] = {$urandom, $urandom};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, no_store, hit, tick and clear at reset settings
        push_req(CMD_LOOKUP, '0, '1, '1, 1'b1);
        push_req(CMD_INSERT, '0, '1, '1, 1'b0);
        push_req(CMD_LOOKUP, '0, '0, '0, 1'b0);
        push_req(CMD_INSERT, '1, 32'h1234_5678, '1, 1'b0);
        push_req(CMD_INSERT, 64'h55, 32'h77, 32'h9, 1'b1);
        push_req(CMD_LOOKUP, 64'h55, '0, '0, 1'b0);
        push_req(CMD_INSERT, '0, 32'h42, '0, 1'b0);
        push_req(CMD_LOOKUP, '1, '1, '1, 1'b1);
        push_req(CMD_LOOKUP, '0, '0, '0, 1'b0);
        push_req(CMD_TICK, '1, '1, '1, 1'b1);
        push_req(CMD_CLEAR, '1, '1, '1, 1'b1);
        push_req(CMD_LOOKUP, '0, '0, '0, 1'b0);

        // short life and small capacity: expiry at lookup and in the sweep
        configure(1'b1, 16'd4, 16'd1);
        for (int j = 2; j < 6; j++) push_req(CMD_INSERT, key_pool[j], j, j, 1'b0);
        push_req(CMD_LOOKUP, key_pool[2], '0, '0, 1'b0);
        push_req(CMD_TICK, '0, '0, '0, 1'b0);
        push_req(CMD_TICK, '0, '0, '0, 1'b0);
        push_req(CMD_LOOKUP, key_pool[3], '0, '0, 1'b0);
        push_req(CMD_INSERT, key_pool[6], 6, 6, 1'b0);
        push_req(CMD_INSERT, key_pool[7], 7, 7, 1'b0);

        // cache switched off
        configure(1'b0, 16'd64, 16'd3600);
        push_req(CMD_INSERT, key_pool[8], 8, 8, 1'b0);
        push_req(CMD_LOOKUP, key_pool[7], '0, '0, 1'b0);

        configure(1'b1, 16'd64, 16'd3600);
        random_batch(300);
        configure(1'b1, 16'd8, 16'd3);
        random_batch(250);
        configure(1'b1, 16'd0, 16'd5);
        random_batch(150);
        configure(1'b1, 16'hFFFF, 16'd20);
        random_batch(300);
        configure(1'b0, 16'd33, 16'd10);
        random_batch(100);
        configure(1'b1, 16'd33, 16'd10);
        random_batch(300);
        configure(1'b1, 16'd1, 16'hFFFF);
        random_batch(150);
        configure(1'b1, 16'd64, 16'd2);
        random_batch(350);

        drain();
        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
